FILE: hdl/fpps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpps_pkg - shared types and constants for the float power block
// Holds the float unit opcodes, the request struct between sequencer and
// float unit, and the state encodings of both state machines.
// ----------------------------------------------------------------------------
package fpps_pkg;

    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    // float unit operations
    typedef enum logic
    {
        OP_MUL,
        OP_RECIP
    } fpps_op_t;

    // request from the sequencer to the float unit
    typedef struct packed
    {
        logic     start;
        fpps_op_t op;
    } fpps_req_t;

    // float unit states
    typedef enum logic [2:0]
    {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_RND,
        F_DONE
    } fpps_fstate_t;

    // sequencer states
    typedef enum logic [2:0]
    {
        S_IDLE,
        S_STEP,
        S_WAIT_ACC,
        S_SQUARE,
        S_WAIT_SQ,
        S_WAIT_REC,
        S_OUT
    } fpps_state_t;

    // unpacked operand: normalized 24-bit significand and exponent of its lsb
    typedef struct packed
    {
        logic              sign;
        logic              nan;
        logic              inf;
        logic              zero;
        logic [23:0]       mant;
        logic signed [9:0] expo;
    } fpps_unpack_t;

endpackage

FILE: hdl/float_power_by_squaring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_power_by_squaring - binary32 base raised to a signed integer power
// Right-to-left square-and-multiply on one shared float unit, with a final
// reciprocal for negative powers.
// ----------------------------------------------------------------------------
// One item at a time: in_ready is high only while the block is idle. Every
// item walks the bits of the exponent magnitude, lowest first. For each bit
// the sequencer decides on the multiply in S_STEP and on the square in
// S_SQUARE; a set bit adds a multiply and every bit below the top set bit
// adds a squaring, each on the shared float unit. A negative exponent adds
// one reciprocal in the bit-serial divider after the last bit.
// The result waits in a register until out_ready takes it.
// ----------------------------------------------------------------------------
module float_power_by_squaring
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        base,
    input  logic signed [31:0] exponent,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        power
);

    fpps_pkg::fpps_state_t state_reg, state_next;
    logic [31:0]           acc_reg, acc_next;
    logic [31:0]           sq_reg, sq_next;
    logic [31:0]           mag_reg, mag_next;
    logic                  neg_reg, neg_next;

    fpps_pkg::fpps_req_t   fpu_req;
    logic [31:0]           fpu_a, fpu_b;
    logic                  fpu_done;
    logic [31:0]           fpu_res;

    fpps_fpu u_fpu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (fpu_req),
        .a      (fpu_a),
        .b      (fpu_b),
        .done   (fpu_done),
        .result (fpu_res)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fpps_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        sq_next       = sq_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        fpu_req.start = 1'b0;
        fpu_req.op    = fpps_pkg::OP_MUL;
        fpu_a         = acc_reg;
        fpu_b         = sq_reg;
        case (state_reg)
            fpps_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next   = fpps_pkg::ONE_BITS;
                    sq_next    = base;
                    neg_next   = exponent[31];
                    mag_next   = exponent[31] ? (32'd0 - exponent) : exponent;
                    state_next = fpps_pkg::S_STEP;
                end
            end
            fpps_pkg::S_STEP:
            begin
                if (mag_reg == 32'd0)
                begin
                    if (neg_reg)
                    begin
                        fpu_req.start = 1'b1;
                        fpu_req.op    = fpps_pkg::OP_RECIP;
                        state_next    = fpps_pkg::S_WAIT_REC;
                    end
                    else
                    begin
                        state_next = fpps_pkg::S_OUT;
                    end
                end
                else if (mag_reg[0])
                begin
                    fpu_req.start = 1'b1;
                    state_next    = fpps_pkg::S_WAIT_ACC;
                end
                else
                begin
                    state_next = fpps_pkg::S_SQUARE;
                end
            end
            fpps_pkg::S_WAIT_ACC:
            begin
                if (fpu_done)
                begin
                    acc_next   = fpu_res;
                    state_next = fpps_pkg::S_SQUARE;
                end
            end
            fpps_pkg::S_SQUARE:
            begin
                // the square after the top set bit is never used
                if (mag_reg[31:1] == 31'd0)
                begin
                    mag_next   = 32'd0;
                    state_next = fpps_pkg::S_STEP;
                end
                else
                begin
                    fpu_req.start = 1'b1;
                    fpu_a         = sq_reg;
                    state_next    = fpps_pkg::S_WAIT_SQ;
                end
            end
            fpps_pkg::S_WAIT_SQ:
            begin
                if (fpu_done)
                begin
                    sq_next    = fpu_res;
                    mag_next   = {1'b0, mag_reg[31:1]};
                    state_next = fpps_pkg::S_STEP;
                end
            end
            fpps_pkg::S_WAIT_REC:
            begin
                if (fpu_done)
                begin
                    acc_next   = fpu_res;
                    state_next = fpps_pkg::S_OUT;
                end
            end
            fpps_pkg::S_OUT:
            begin
                if (out_ready)
                    state_next = fpps_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fpps_pkg::S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == fpps_pkg::S_IDLE);
    assign out_valid = (state_reg == fpps_pkg::S_OUT);

    // any nan leaves as the canonical quiet nan
    assign power = ((&acc_reg[30:23]) && (|acc_reg[22:0])) ? fpps_pkg::CANON_NAN : acc_reg;

    // no new item while a result is on offer
    a_ready_vs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid high together");

    // an accepted item never yields a result in the next cycle
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("result offered right after accept");

    // the float unit only finishes while the sequencer waits on it
    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        fpu_done |-> (state_reg == fpps_pkg::S_WAIT_ACC || state_reg == fpps_pkg::S_WAIT_SQ
                      || state_reg == fpps_pkg::S_WAIT_REC))
        else $error("float unit done outside a wait state");

endmodule

FILE: hdl/fpps_fpu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpps_fpu - shared binary32 multiply / reciprocal unit
// Multiply: unpack, 24x24 product, shift and round.
// Reciprocal: unpack, 27-step restoring division, round.
// Round to nearest even with gradual underflow; NaN results are canonical.
// ----------------------------------------------------------------------------
module fpps_fpu
(
    input  logic                clk,
    input  logic                rst_n,
    input  fpps_pkg::fpps_req_t req,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    output logic                done,
    output logic [31:0]         result
);

    fpps_pkg::fpps_fstate_t state_reg, state_next;
    fpps_pkg::fpps_op_t     op_reg, op_next;
    logic                   sign_reg, sign_next;
    logic [23:0]            ma_reg, ma_next;
    logic [23:0]            mb_reg, mb_next;
    logic signed [10:0]     e_reg, e_next;
    logic [47:0]            prod_reg, prod_next;
    logic [26:0]            q_reg, q_next;
    logic [24:0]            rem_reg, rem_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic [31:0]            res_reg, res_next;

    fpps_pkg::fpps_unpack_t ua, ub;
    logic                   spec;
    logic [31:0]            spec_val;
    logic [24:0]            rem_sub;
    logic                   qbit;
    logic [31:0]            rnd_res;

    // split a binary32 pattern into a normalized significand and exponent
    function automatic fpps_pkg::fpps_unpack_t unpack(input logic [31:0] x);
        fpps_pkg::fpps_unpack_t u;
        logic [23:0]            m;
        logic [4:0]             lz;
        logic                   found;
        m     = {(x[30:23] != 8'd0), x[22:0]};
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--)
        begin
            if (!found && m[i])
            begin
                lz    = 5'(23 - i);
                found = 1'b1;
            end
        end
        u.sign = x[31];
        u.nan  = (&x[30:23]) && (|x[22:0]);
        u.inf  = (&x[30:23]) && !(|x[22:0]);
        u.zero = (x[30:0] == 31'd0);
        u.mant = m << lz;
        if (x[30:23] != 8'd0)
            u.expo = $signed({2'b00, x[30:23]}) - 10'sd150;
        else
            u.expo = -10'sd149 - $signed({5'b00000, lz});
        return u;
    endfunction

    assign ua = unpack(a);
    assign ub = unpack(b);

    // special operands
    always_comb
    begin
        spec     = 1'b0;
        spec_val = fpps_pkg::CANON_NAN;
        if (req.op == fpps_pkg::OP_MUL)
        begin
            if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf))
            begin
                spec     = 1'b1;
                spec_val = fpps_pkg::CANON_NAN;
            end
            else if (ua.inf || ub.inf)
            begin
                spec     = 1'b1;
                spec_val = {ua.sign ^ ub.sign, fpps_pkg::INF_BITS[30:0]};
            end
            else if (ua.zero || ub.zero)
            begin
                spec     = 1'b1;
                spec_val = {ua.sign ^ ub.sign, 31'd0};
            end
        end
        else
        begin
            if (ua.nan)
            begin
                spec     = 1'b1;
                spec_val = fpps_pkg::CANON_NAN;
            end
            else if (ua.inf)
            begin
                spec     = 1'b1;
                spec_val = {ua.sign, 31'd0};
            end
            else if (ua.zero)
            begin
                spec     = 1'b1;
                spec_val = {ua.sign, fpps_pkg::INF_BITS[30:0]};
            end
        end
    end

    // one restoring division step
    assign qbit    = (rem_reg >= {1'b0, ma_reg});
    assign rem_sub = qbit ? (rem_reg - {1'b0, ma_reg}) : rem_reg;

    // shift to the result quantum, round to nearest even, pack
    always_comb
    begin
        logic [47:0]        p;
        logic               xs;
        logic signed [11:0] be;
        logic [11:0]        shw;
        logic [5:0]         sh;
        logic [8:0]         base;
        logic [97:0]        wide;
        logic [24:0]        q;
        logic               r;
        logic               s;
        logic [25:0]        qr;
        logic [33:0]        sum;
        p    = (op_reg == fpps_pkg::OP_RECIP) ? {q_reg, 21'd0} : prod_reg;
        xs   = (op_reg == fpps_pkg::OP_RECIP) && (rem_reg != 25'd0);
        be   = 12'(e_reg) + (p[47] ? 12'sd174 : 12'sd173);
        base = 9'd0;
        if (be >= 12'sd1)
        begin
            shw  = p[47] ? 12'd24 : 12'd23;
            base = 9'(be - 12'sd1);
        end
        else
        begin
            shw = (p[47] ? 12'd24 : 12'd23) + 12'(12'sd1 - be);
        end
        sh   = (shw > 12'd63) ? 6'd63 : shw[5:0];
        wide = {p, 50'd0} >> sh;
        q    = wide[74:50];
        r    = wide[49];
        s    = (|wide[48:0]) || xs;
        qr   = 26'(q) + 26'(r && (s || q[0]));
        sum  = ({25'd0, base} << 23) + 34'(qr);
        if (sum >= 34'(fpps_pkg::INF_BITS))
            rnd_res = {sign_reg, fpps_pkg::INF_BITS[30:0]};
        else
            rnd_res = {sign_reg, sum[30:0]};
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fpps_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        sign_reg <= sign_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        e_reg    <= e_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        sign_next  = sign_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        e_next     = e_reg;
        prod_next  = prod_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        case (state_reg)
            fpps_pkg::F_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    ma_next  = ua.mant;
                    mb_next  = ub.mant;
                    rem_next = 25'h080_0000;
                    q_next   = 27'd0;
                    cnt_next = 5'd0;
                    if (req.op == fpps_pkg::OP_MUL)
                    begin
                        sign_next  = ua.sign ^ ub.sign;
                        e_next     = 11'(ua.expo) + 11'(ub.expo);
                        state_next = fpps_pkg::F_MUL;
                    end
                    else
                    begin
                        sign_next  = ua.sign;
                        e_next     = -11'sd70 - 11'(ua.expo);
                        state_next = fpps_pkg::F_DIV;
                    end
                    if (spec)
                    begin
                        res_next   = spec_val;
                        state_next = fpps_pkg::F_DONE;
                    end
                end
            end
            fpps_pkg::F_MUL:
            begin
                prod_next  = 48'(ma_reg) * 48'(mb_reg);
                state_next = fpps_pkg::F_RND;
            end
            fpps_pkg::F_DIV:
            begin
                q_next   = {q_reg[25:0], qbit};
                rem_next = {rem_sub[23:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd26)
                    state_next = fpps_pkg::F_RND;
            end
            fpps_pkg::F_RND:
            begin
                res_next   = rnd_res;
                state_next = fpps_pkg::F_DONE;
            end
            fpps_pkg::F_DONE:
            begin
                state_next = fpps_pkg::F_IDLE;
            end
            default:
            begin
                state_next = fpps_pkg::F_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == fpps_pkg::F_DONE);
    assign result = res_reg;

endmodule
